>>> hdl/kp800_pkg.sv
// ----------------------------------------------------------------------------
// kp800_pkg
// Shared types, constants and the Keccak-p[800] round function.
// ----------------------------------------------------------------------------
package kp800_pkg;

   localparam int LANE_W      = 32;
   localparam int LANE_COUNT  = 25;
   localparam int FULL_ROUNDS = 22;
   localparam int DEF_ROUNDS  = 12;
   localparam int IDX_W       = 5;

   typedef logic [LANE_W-1:0] lane_type;
   typedef logic [LANE_COUNT-1:0][LANE_W-1:0] lane_array_type;

   typedef struct packed {
      logic              shift_en;
      logic              round_en;
      logic [IDX_W-1:0]  round_idx;
   } dp_cmd_type;

   localparam logic [IDX_W-1:0] ROT_AMOUNT [LANE_COUNT] = '{
      5'd0,  5'd1,  5'd30, 5'd28, 5'd27, 5'd4,  5'd12, 5'd6,  5'd23,
      5'd20, 5'd3,  5'd10, 5'd11, 5'd25, 5'd7,  5'd9,  5'd13, 5'd15,
      5'd21, 5'd8,  5'd18, 5'd2,  5'd29, 5'd24, 5'd14
   };

   function automatic lane_type round_const(logic [IDX_W-1:0] idx);
      lane_type rc;
      case (idx)
         5'd0:    rc = 32'h0000_0001;
         5'd1:    rc = 32'h0000_8082;
         5'd2:    rc = 32'h0000_808a;
         5'd3:    rc = 32'h8000_8000;
         5'd4:    rc = 32'h0000_808b;
         5'd5:    rc = 32'h8000_0001;
         5'd6:    rc = 32'h8000_8081;
         5'd7:    rc = 32'h0000_8009;
         5'd8:    rc = 32'h0000_008a;
         5'd9:    rc = 32'h0000_0088;
         5'd10:   rc = 32'h8000_8009;
         5'd11:   rc = 32'h8000_000a;
         5'd12:   rc = 32'h8000_808b;
         5'd13:   rc = 32'h0000_008b;
         5'd14:   rc = 32'h0000_8089;
         5'd15:   rc = 32'h0000_8003;
         5'd16:   rc = 32'h0000_8002;
         5'd17:   rc = 32'h0000_0080;
         5'd18:   rc = 32'h0000_800a;
         5'd19:   rc = 32'h8000_000a;
         5'd20:   rc = 32'h8000_8081;
         5'd21:   rc = 32'h0000_8080;
         default: rc = '0;
      endcase
      return rc;
   endfunction

   function automatic lane_type rotl(lane_type v, logic [IDX_W-1:0] n);
      logic [2*LANE_W-1:0] t;
      t = {v, v} << n;
      return t[2*LANE_W-1:LANE_W];
   endfunction

   // theta, rho, pi, chi, iota
   function automatic lane_array_type keccak_round(lane_array_type a,
                                                   logic [IDX_W-1:0] idx);
      lane_type [4:0] c;
      lane_type [4:0] d;
      lane_array_type b;
      lane_array_type r;
      for (int x = 0; x < 5; x++) begin
         c[x] = a[x] ^ a[x+5] ^ a[x+10] ^ a[x+15] ^ a[x+20];
      end
      for (int x = 0; x < 5; x++) begin
         d[x] = rotl(c[(x+1)%5], 5'd1) ^ c[(x+4)%5];
      end
      for (int y = 0; y < 5; y++) begin
         for (int x = 0; x < 5; x++) begin
            b[y + 5*((2*x + 3*y) % 5)] = rotl(a[x+5*y] ^ d[x], ROT_AMOUNT[x+5*y]);
         end
      end
      for (int y = 0; y < 5; y++) begin
         for (int x = 0; x < 5; x++) begin
            r[x+5*y] = b[x+5*y] ^ (~b[(x+1)%5 + 5*y] & b[(x+2)%5 + 5*y]);
         end
      end
      r[0] = r[0] ^ round_const(idx);
      return r;
   endfunction

endpackage

>>> hdl/kp800_datapath.sv
// ----------------------------------------------------------------------------
// kp800_datapath
// State register: lane shift line for load and unload, one round per cycle.
// ----------------------------------------------------------------------------
module kp800_datapath (
   input  logic                  clock,
   input  kp800_pkg::dp_cmd_type cmd,
   input  kp800_pkg::lane_type   lane_in,
   output kp800_pkg::lane_type   lane_out
);

   kp800_pkg::lane_array_type state_ff;
   kp800_pkg::lane_array_type state_in;

   always_comb begin
      state_in = state_ff;
      priority if (cmd.round_en) begin
         state_in = kp800_pkg::keccak_round(state_ff, cmd.round_idx);
      end else if (cmd.shift_en) begin
         for (int i = 0; i < kp800_pkg::LANE_COUNT - 1; i++) begin
            state_in[i] = state_ff[i+1];
         end
         state_in[kp800_pkg::LANE_COUNT-1] = lane_in;
      end else begin
         state_in = state_ff;
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
   end

   assign lane_out = state_ff[0];

endmodule

>>> hdl/kp800_ctrl.sv
// ----------------------------------------------------------------------------
// kp800_ctrl
// Sequencer: lane load count, round count and lane unload count.
// ----------------------------------------------------------------------------
module kp800_ctrl #(
   parameter int ROUNDS = kp800_pkg::DEF_ROUNDS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   output kp800_pkg::dp_cmd_type         cmd,
   output logic                          rsp_strobe,
   output logic [kp800_pkg::IDX_W-1:0]   rsp_lane_number,
   output logic                          rsp_last_lane
);

   localparam logic [1:0] ST_LOAD  = 2'd0;
   localparam logic [1:0] ST_ROUND = 2'd1;
   localparam logic [1:0] ST_EMIT  = 2'd2;

   localparam logic [kp800_pkg::IDX_W-1:0] FIRST_ROUND =
      kp800_pkg::IDX_W'(kp800_pkg::FULL_ROUNDS - ROUNDS);
   localparam logic [kp800_pkg::IDX_W-1:0] LAST_ROUND =
      kp800_pkg::IDX_W'(kp800_pkg::FULL_ROUNDS - 1);
   localparam logic [kp800_pkg::IDX_W-1:0] LAST_LANE =
      kp800_pkg::IDX_W'(kp800_pkg::LANE_COUNT - 1);

   logic [1:0]                    st_ff, st_in;
   logic [kp800_pkg::IDX_W-1:0]   cnt_ff, cnt_in;
   logic [kp800_pkg::IDX_W-1:0]   rnd_ff, rnd_in;
   logic                          accept;

   assign accept = start && (st_ff == ST_LOAD);

   always_comb begin
      st_in         = st_ff;
      cnt_in        = cnt_ff;
      rnd_in        = rnd_ff;
      cmd.shift_en  = 1'b0;
      cmd.round_en  = 1'b0;
      cmd.round_idx = rnd_ff;
      unique case (st_ff)
         ST_LOAD: begin
            if (accept) begin
               cmd.shift_en = 1'b1;
               if (cnt_ff == LAST_LANE) begin
                  cnt_in = '0;
                  rnd_in = FIRST_ROUND;
                  st_in  = ST_ROUND;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            rnd_in       = rnd_ff + 1'b1;
            if (rnd_ff == LAST_ROUND) begin
               st_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.shift_en = 1'b1;
            if (cnt_ff == LAST_LANE) begin
               cnt_in = '0;
               st_in  = ST_LOAD;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: begin
            cnt_in = '0;
            st_in  = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_LOAD;
         cnt_ff <= '0;
         rnd_ff <= '0;
      end else begin
         st_ff  <= st_in;
         cnt_ff <= cnt_in;
         rnd_ff <= rnd_in;
      end
   end

   assign busy            = (st_ff != ST_LOAD);
   assign rsp_strobe      = (st_ff == ST_EMIT);
   assign rsp_lane_number = cnt_ff;
   assign rsp_last_lane   = (st_ff == ST_EMIT) && (cnt_ff == LAST_LANE);

endmodule

>>> hdl/keccak_p800_permutation.sv
// ----------------------------------------------------------------------------
// keccak_p800_permutation
// Keccak-p[800] permutation over the last ROUNDS rounds, lane serial in/out.
// ----------------------------------------------------------------------------
// usage
//   input beats: drive req_lane_in with start high; a beat is taken on each
//   clock edge where start is high and busy is low. lanes 0 to 24, in order.
//   after the 25th beat busy rises; ROUNDS rounds follow, one round
//   per cycle in the datapath's round logic.
//   output beats: rsp_strobe high on consecutive cycles, one lane each,
//   rsp_lane_number counting 0 to 24, rsp_last_lane high on lane 24. each
//   beat stands for exactly one cycle; the receiver cannot stall it.
//   busy falls the cycle after the last output beat.
//   a new state's lanes are taken only after the last output beat of the
//   previous one; load and unload share the single lane-wide shift line.
//   reset: synchronous; partly loaded lanes are dropped and the next beat is
//   taken as lane 0.
// ----------------------------------------------------------------------------
module keccak_p800_permutation #(
   parameter int ROUNDS = kp800_pkg::DEF_ROUNDS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [31:0]                 req_lane_in,
   output logic                        rsp_strobe,
   output logic [31:0]                 rsp_lane_out,
   output logic [4:0]                  rsp_lane_number,
   output logic                        rsp_last_lane
);

   kp800_pkg::dp_cmd_type cmd;

   kp800_ctrl #(
      .ROUNDS (ROUNDS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .cmd             (cmd),
      .rsp_strobe      (rsp_strobe),
      .rsp_lane_number (rsp_lane_number),
      .rsp_last_lane   (rsp_last_lane)
   );

   kp800_datapath u_datapath (
      .clock    (clock),
      .cmd      (cmd),
      .lane_in  (req_lane_in),
      .lane_out (rsp_lane_out)
   );

`ifndef SYNTH
   a_strobe_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("output beat while not busy");

   a_last_idle : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last_lane) |=> !busy && !rsp_strobe)
      else $error("block not idle after last lane");

   a_lane_seq : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_lane) |=>
         rsp_strobe && (rsp_lane_number == $past(rsp_lane_number) + 5'd1))
      else $error("output lanes not consecutive");

   a_no_round_cmd_idle : assert property (@(posedge clock) disable iff (reset)
      !busy |-> !cmd.round_en)
      else $error("round applied while loading");
`endif

endmodule
